### rtl/core/screen_byte_pixel_decoder_defines.svh
// Assertion helpers for the screen byte pixel decoder.
`ifndef SCREEN_BYTE_PIXEL_DECODER_DEFINES_SVH
`define SCREEN_BYTE_PIXEL_DECODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SBPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define SBPD_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

### rtl/core/sbpd_pkg.sv
package sbpd_pkg;

  localparam int unsigned NCELL    = 8;
  localparam int unsigned X_W      = 10;
  localparam int unsigned Y_W      = 8;
  localparam int unsigned COL_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PAL_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COLUMN_W = 7;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned LINE_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_PAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE      = 2'd2;

  // Display modes; the eighth code is undefined and decodes no pixels
  typedef enum logic [2:0] {
    MODE0 = 3'd0,
    MODE1 = 3'd1,
    MODE2 = 3'd2,
    MODE3 = 3'd3,
    MODE4 = 3'd4,
    MODE5 = 3'd5,
    MODE6 = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    KIND_TWO   = 2'd0,
    KIND_FOUR  = 2'd1,
    KIND_EIGHT = 2'd2
  } kind_e;

  // One decoded pixel as held in a chain cell
  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [COL_W-1:0] lc;
    logic [COL_W-1:0] pc;
    logic             last;
    logic             frame;
  } pix_t;

  // Per-cycle chain control
  typedef struct packed {
    logic adv;
    logic load;
  } cell_ctl_t;

  // Configuration write
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [PAL_W-1:0]     data;
  } cfg_wr_t;

endpackage

### rtl/core/sbpd_if.sv
// Screen byte channel
interface sbpd_byte_if;
  logic                        valid;
  logic                        ready;
  logic [sbpd_pkg::BYTE_W-1:0] screen_byte;

  modport source (output valid, output screen_byte, input ready);
  modport sink   (input valid, input screen_byte, output ready);
endinterface

// Pixel channel
interface sbpd_pix_if;
  logic                       valid;
  logic                       ready;
  logic [sbpd_pkg::X_W-1:0]   pixel_x;
  logic [sbpd_pkg::Y_W-1:0]   pixel_y;
  logic [sbpd_pkg::COL_W-1:0] logical_colour;
  logic [sbpd_pkg::COL_W-1:0] physical_colour;
  logic                       last_of_byte;
  logic                       frame_done;

  modport source (output valid, output pixel_x, output pixel_y, output logical_colour,
                  output physical_colour, output last_of_byte, output frame_done,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input logical_colour,
                  input physical_colour, input last_of_byte, input frame_done,
                  output ready);
endinterface

### rtl/core/screen_byte_pixel_decoder.sv
// Channel | Dir | Word                   | Accept
// src_i   | in  | one screen byte        | valid && ready at clk_i rise
// pix_o   | out | one pixel with x and y | valid && ready at clk_i rise
// cfg     | in  | register write         | cfg_we_i at clk_i rise
//
// One pixel leaves per cycle while pix_o.ready is high; a byte yields 8, 4 or 2
// pixels (two-, four-, eight-colour) through cell 0 of the eight-cell shift chain.
// The next byte is taken in the cycle the last pixel of the previous byte leaves.
// A byte in the undefined mode is taken and yields no pixels.
// Reset clears the counters, the configuration and every cell's valid bit.
// A low pix_o.ready holds the whole chain in place.
`include "screen_byte_pixel_decoder_defines.svh"

module screen_byte_pixel_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sbpd_byte_if.sink                      src_i,
  sbpd_pix_if.source                     pix_o,
  input  logic                           cfg_we_i,
  input  logic [sbpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sbpd_pkg::PAL_W-1:0]     cfg_data_i
);
  import sbpd_pkg::*;

  cfg_wr_t                cfg;
  cell_ctl_t              ctl;
  logic                   fire;
  logic [NCELL-1:0]       load_vld;
  pix_t [NCELL-1:0]       load_pix;
  logic [NCELL-1:0]       vld;
  pix_t [NCELL-1:0]       pix;
  logic [NCELL-1:0]       nb_vld;
  pix_t [NCELL-1:0]       nb_pix;
  logic [NCELL:0]         vld_inc;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // Advance when the head is empty or taken; load once only the head remains
  assign ctl.adv     = !vld[0] || pix_o.ready;
  assign src_i.ready = !(|vld[NCELL-1:1]) && ctl.adv;
  assign fire        = src_i.valid && src_i.ready;
  assign ctl.load    = fire;

  sbpd_loader u_loader (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .fire_i     (fire),
    .byte_i     (src_i.screen_byte),
    .load_vld_o (load_vld),
    .load_pix_o (load_pix)
  );

  // Feed each cell from its upper neighbor; the top cell drains to empty
  always_comb begin
    for (int i = 0; i < NCELL - 1; i++) begin
      nb_vld[i] = vld[i+1];
      nb_pix[i] = pix[i+1];
    end
    nb_vld[NCELL-1] = 1'b0;
    nb_pix[NCELL-1] = pix[NCELL-1];
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    sbpd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .load_vld_i (load_vld[g]),
      .load_pix_i (load_pix[g]),
      .nb_vld_i   (nb_vld[g]),
      .nb_pix_i   (nb_pix[g]),
      .vld_o      (vld[g]),
      .pix_o      (pix[g])
    );
  end

  // Head cell drives the output word
  assign pix_o.valid           = vld[0];
  assign pix_o.pixel_x         = pix[0].x;
  assign pix_o.pixel_y         = pix[0].y;
  assign pix_o.logical_colour  = pix[0].lc;
  assign pix_o.physical_colour = pix[0].pc;
  assign pix_o.last_of_byte    = pix[0].last;
  assign pix_o.frame_done      = pix[0].frame;

  // Valid cells always form an unbroken run from the head
  assign vld_inc = {1'b0, vld} + (NCELL+1)'(1);

  `SBPD_ASSERT(a_chain_packed, $onehot0(vld_inc), "chain has a hole")
  `SBPD_ASSERT_IMP(a_last_alone, vld[0] && pix[0].last, !(|vld[NCELL-1:1]), "pixels after last")
  `SBPD_ASSERT_IMP(a_frame_last, vld[0] && pix[0].frame, pix[0].last, "frame end mid byte")
  `SBPD_ASSERT_IMP(a_load_empty, fire, !(|vld[NCELL-1:1]), "byte loaded over live pixels")

endmodule

### rtl/core/sbpd_cell.sv
module sbpd_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sbpd_pkg::cell_ctl_t   ctl_i,
  input  logic                  load_vld_i,
  input  sbpd_pkg::pix_t        load_pix_i,
  input  logic                  nb_vld_i,
  input  sbpd_pkg::pix_t        nb_pix_i,
  output logic                  vld_o,
  output sbpd_pkg::pix_t        pix_o
);
  import sbpd_pkg::*;

  logic vld_q;
  pix_t pix_q;

  // Take a fresh pixel on load, otherwise take the neighbor's on advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.load) begin
      vld_q <= load_vld_i;
    end else if (ctl_i.adv) begin
      vld_q <= nb_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      pix_q <= load_pix_i;
    end else if (ctl_i.adv) begin
      pix_q <= nb_pix_i;
    end
  end

  assign vld_o = vld_q;
  assign pix_o = pix_q;

endmodule

### rtl/core/sbpd_loader.sv
module sbpd_loader (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sbpd_pkg::cfg_wr_t                   cfg_i,
  input  logic                                fire_i,
  input  logic [sbpd_pkg::BYTE_W-1:0]         byte_i,
  output logic [sbpd_pkg::NCELL-1:0]          load_vld_o,
  output sbpd_pkg::pix_t [sbpd_pkg::NCELL-1:0] load_pix_o
);
  import sbpd_pkg::*;

  logic [2:0]          mode_q;
  logic                cust_q;
  logic [PAL_W-1:0]    pal_q;
  logic [LINE_W-1:0]   line_q, line_d;
  logic [COLUMN_W-1:0] colm_q, colm_d;
  logic [ROW_W-1:0]    row_q, row_d;

  logic                mode_ok;
  kind_e               kind;
  logic [COLUMN_W-1:0] last_col;
  logic [ROW_W-1:0]    last_row;
  logic                gap;
  logic [3:0]          npix;
  logic [X_W-1:0]      x0;
  logic [9:0]          y_full;
  logic                col_end, row_end, frame_end;

  // Logical colour of pixel idx; bit positions wrap at three bits
  function automatic logic [COL_W-1:0] decode_px(kind_e k, logic [BYTE_W-1:0] b,
                                                 logic [2:0] idx);
    logic [COL_W-1:0] r;
    r = '0;
    unique case (k)
      KIND_TWO:   r = {2'b00, b[3'd7 - idx]};
      KIND_FOUR:  r = {1'b0, b[3'd7 - idx], b[3'd3 - idx]};
      KIND_EIGHT: r = {b[3'd5 - idx], b[3'd3 - idx], b[3'd1 - idx]};
      default:    r = '0;
    endcase
    return r;
  endfunction

  // Built-in palette of each colour depth
  function automatic logic [COL_W-1:0] default_pal(kind_e k, logic [COL_W-1:0] lc);
    logic [COL_W-1:0] r;
    r = '0;
    unique case (k)
      KIND_TWO: r = lc[0] ? 3'd7 : 3'd0;
      KIND_FOUR: begin
        case (lc[1:0])
          2'd0:    r = 3'd0;
          2'd1:    r = 3'd1;
          2'd2:    r = 3'd3;
          default: r = 3'd7;
        endcase
      end
      KIND_EIGHT: r = lc;
      default:    r = lc;
    endcase
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      cust_q <= 1'b0;
      pal_q  <= '0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_DISPLAY_MODE: mode_q <= cfg_i.data[2:0];
        CFG_CUSTOM_PAL:   cust_q <= cfg_i.data[0];
        CFG_PALETTE:      pal_q  <= cfg_i.data;
        default:          ;
      endcase
    end
  end

  // Mode decode
  always_comb begin
    mode_ok  = 1'b1;
    kind     = KIND_TWO;
    last_col = 7'd79;
    last_row = 5'd31;
    gap      = 1'b0;
    unique case (mode_q)
      MODE0: ;
      MODE1: kind = KIND_FOUR;
      MODE2: kind = KIND_EIGHT;
      MODE3: begin
        last_row = 5'd24;
        gap      = 1'b1;
      end
      MODE4: last_col = 7'd39;
      MODE5: begin
        kind     = KIND_FOUR;
        last_col = 7'd39;
      end
      MODE6: begin
        last_col = 7'd39;
        last_row = 5'd24;
        gap      = 1'b1;
      end
      default: mode_ok = 1'b0;
    endcase
  end

  // Byte position and raster coordinates
  always_comb begin
    unique case (kind)
      KIND_TWO: begin
        npix = 4'd8;
        x0   = {colm_q, 3'b000};
      end
      KIND_FOUR: begin
        npix = 4'd4;
        x0   = {1'b0, colm_q, 2'b00};
      end
      KIND_EIGHT: begin
        npix = 4'd2;
        x0   = {2'b00, colm_q, 1'b0};
      end
      default: begin
        npix = 4'd8;
        x0   = {colm_q, 3'b000};
      end
    endcase
    y_full = {2'b00, row_q, 3'b000} + {7'd0, line_q}
           + (gap ? {4'd0, row_q, 1'b0} : 10'd0);
    col_end   = colm_q >= last_col;
    row_end   = row_q >= last_row;
    frame_end = (line_q == 3'd7) && col_end && row_end;
  end

  // Build the eight pixel records for the chain
  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      logic [COL_W-1:0] lc;
      lc = decode_px(kind, byte_i, i[2:0]);
      load_vld_o[i]       = mode_ok && (i[3:0] < npix);
      load_pix_o[i].x     = x0 + X_W'(i);
      load_pix_o[i].y     = y_full[Y_W-1:0];
      load_pix_o[i].lc    = lc;
      load_pix_o[i].pc    = cust_q ? pal_q[3*lc +: 3] : default_pal(kind, lc);
      load_pix_o[i].last  = (i[3:0] + 4'd1) == npix;
      load_pix_o[i].frame = ((i[3:0] + 4'd1) == npix) && frame_end;
    end
  end

  // Advance the screen counters after every byte in a defined mode
  always_comb begin
    line_d = line_q;
    colm_d = colm_q;
    row_d  = row_q;
    if (fire_i && mode_ok) begin
      if (line_q == 3'd7) begin
        line_d = '0;
        if (col_end) begin
          colm_d = '0;
          row_d  = row_end ? '0 : row_q + 5'd1;
        end else begin
          colm_d = colm_q + 7'd1;
        end
      end else begin
        line_d = line_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      colm_q <= '0;
      row_q  <= '0;
    end else begin
      line_q <= line_d;
      colm_q <= colm_d;
      row_q  <= row_d;
    end
  end

endmodule

### bench/tb_top.sv
module tb_top;
  import sbpd_pkg::*;

  // The mode code that the package leaves out; it decodes no pixels
  localparam logic [2:0] MODE_UNDEF     = 3'd7;
  localparam int         SETTLE_CYCLES  = 16;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RANDOM_BYTES   = 100;
  localparam int         MAX_REPORTS    = 60;

  // Mirror of the decoder: configuration, raster counters and the pixels still due
  class pixel_tracker;
    logic [2:0]          mode        = '0;
    logic                custom      = 1'b0;
    logic [PAL_W-1:0]    palette     = '0;
    logic [LINE_W-1:0]   cell_line   = '0;
    logic [COLUMN_W-1:0] byte_column = '0;
    logic [ROW_W-1:0]    text_row    = '0;
    pix_t                due_pixels[$];
    int unsigned         errors      = 0;

    function void fail(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $error("%s", msg);
    endfunction

    function void compare(string field, int exp_val, int got_val);
      if (exp_val != got_val)
        fail($sformatf("%s: expected %0d, got %0d", field, exp_val, got_val));
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAL_W-1:0] data);
      case (idx)
        CFG_DISPLAY_MODE: mode = data[2:0];
        CFG_CUSTOM_PAL:   custom = data[0];
        CFG_PALETTE:      palette = data;
        default: ;
      endcase
    endfunction

    // Split one byte into its pixels and advance the raster counters
    function void take_byte(logic [BYTE_W-1:0] b);
      kind_e            kind;
      int               npix;
      int               ncols;
      int               nrows;
      int               gap_lines;
      int               x0;
      int               y0;
      logic             frame_end;
      logic [COL_W-1:0] lc;
      logic [PAL_W-1:0] shifted;
      pix_t             p;
      if (mode == MODE_UNDEF) return;
      case (mode)
        MODE1, MODE5: kind = KIND_FOUR;
        MODE2:        kind = KIND_EIGHT;
        default:      kind = KIND_TWO;
      endcase
      npix      = (kind == KIND_TWO) ? 8 : ((kind == KIND_FOUR) ? 4 : 2);
      ncols     = (mode <= MODE3) ? 80 : 40;
      nrows     = (mode == MODE3 || mode == MODE6) ? 25 : 32;
      gap_lines = (mode == MODE3 || mode == MODE6) ? 2 : 0;
      x0        = int'(byte_column) * npix;
      y0        = int'(text_row) * (8 + gap_lines) + int'(cell_line);
      frame_end = (cell_line == 3'd7) && (byte_column >= ncols - 1) && (text_row >= nrows - 1);

      for (int i = 0; i < npix; i++) begin
        case (kind)
          KIND_TWO:  lc = {2'b00, b[7 - i]};
          KIND_FOUR: lc = {1'b0, b[7 - i], b[3 - i]};
          default:   lc = {b[5 - i], b[3 - i], b[1 - i]};
        endcase
        p.x  = X_W'(x0 + i);
        p.y  = Y_W'(y0);
        p.lc = lc;
        // Built-in palettes: black/white, a 0-1-3-7 ramp, identity
        if (custom) begin
          shifted = palette >> (3 * int'(lc));
          p.pc    = shifted[2:0];
        end else begin
          case (kind)
            KIND_TWO:  p.pc = lc[0] ? 3'd7 : 3'd0;
            KIND_FOUR: p.pc = {lc[1] & lc[0], lc[1], lc[1] | lc[0]};
            default:   p.pc = lc;
          endcase
        end
        p.last  = (i == npix - 1);
        p.frame = (i == npix - 1) && frame_end;
        due_pixels.push_back(p);
      end

      // A counter past the mode's end counts as the last value
      if (cell_line == 3'd7) begin
        cell_line = '0;
        if (byte_column >= ncols - 1) begin
          byte_column = '0;
          if (text_row >= nrows - 1) text_row = '0;
          else text_row = text_row + 1'b1;
        end else begin
          byte_column = byte_column + 1'b1;
        end
      end else begin
        cell_line = cell_line + 1'b1;
      end
    endfunction

    function void check_pixel(pix_t got);
      pix_t exp_pix;
      if (due_pixels.size() == 0) begin
        fail($sformatf("pixel at x %0d y %0d with none due", got.x, got.y));
        return;
      end
      exp_pix = due_pixels.pop_front();
      compare("pixel_x", int'(exp_pix.x), int'(got.x));
      compare("pixel_y", int'(exp_pix.y), int'(got.y));
      compare("logical_colour", int'(exp_pix.lc), int'(got.lc));
      compare("physical_colour", int'(exp_pix.pc), int'(got.pc));
      compare("last_of_byte", int'(exp_pix.last), int'(got.last));
      compare("frame_done", int'(exp_pix.frame), int'(got.frame));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [PAL_W-1:0]     cfg_data;
  bit                   no_gaps = 1'b0;
  int                   stall_cycles = 0;
  pixel_tracker         tracker = new();

  sbpd_byte_if byte_ch ();
  sbpd_pix_if  pix_ch ();

  screen_byte_pixel_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .src_i      (byte_ch),
    .pix_o      (pix_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [PAL_W-1:0] rand_palette();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return PAL_W'($urandom);
  endfunction

  // Offer one word and hold it until taken
  task automatic send_byte(input logic [BYTE_W-1:0] value);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.screen_byte <= value;
    do @(posedge clk_i); while (!byte_ch.ready);
    tracker.take_byte(value);
  endtask

  // Drop valid and wait for every due pixel, plus the tail of the chain
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (tracker.due_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAL_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // Reprogram all registers once the decoder has gone quiet
  task automatic reprogram(input logic [2:0] mode, input logic custom,
                           input logic [PAL_W-1:0] palette);
    drain();
    write_reg(CFG_DISPLAY_MODE, PAL_W'(mode));
    write_reg(CFG_CUSTOM_PAL, PAL_W'(custom));
    write_reg(CFG_PALETTE, palette);
    cfg_we <= 1'b0;
  endtask

  // Feed random bytes until the counters sit at the start of the given cell
  task automatic walk_to(input int row, input int col);
    while (!(tracker.text_row == row && tracker.byte_column == col && tracker.cell_line == 0))
      send_byte(rand_byte());
  endtask

  // Receiver: random stalls, with long stretches of none
  initial begin
    int   hold;
    int   roll;
    logic level;
    pix_ch.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          level = 1'b1;
          hold  = $urandom_range(0, 15);
        end else if (roll < 85) begin
          level = 1'b0;
          hold  = $urandom_range(0, 2);
        end else if (roll < 95) begin
          level = 1'b1;
          hold  = $urandom_range(50, 200);
        end else begin
          level = 1'b0;
          hold  = $urandom_range(10, 40);
        end
        pix_ch.ready <= level;
      end else begin
        hold--;
      end
    end
  end

  // Check every pixel word taken
  always @(posedge clk_i) begin
    if (rst_ni && pix_ch.valid && pix_ch.ready)
      tracker.check_pixel({pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.logical_colour,
                           pix_ch.physical_colour, pix_ch.last_of_byte, pix_ch.frame_done});
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      if (tracker.due_pixels.size() != 0)
        $error("%0d pixels never arrived", tracker.due_pixels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [2:0] mode;
    int         count;
    int         taken;
    rst_ni              <= 1'b0;
    byte_ch.valid       <= 1'b0;
    byte_ch.screen_byte <= '0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_DISPLAY_MODE;
    cfg_data            <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: two-colour mode with the built-in palette
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hA5);
    reprogram(MODE1, 1'b0, '0);
    send_byte(8'hF0);
    send_byte(8'h0F);
    send_byte(8'h5A);
    reprogram(MODE2, 1'b0, '0);
    send_byte(8'h2A);
    send_byte(8'h15);
    reprogram(MODE2, 1'b1, 24'hFFFFFF);
    send_byte(8'h3F);
    reprogram(MODE2, 1'b1, 24'o01234567);
    send_byte(8'hC3);
    send_byte(8'h2A);
    reprogram(MODE5, 1'b1, 24'h000000);
    send_byte(8'hA5);
    // Undefined mode swallows bytes and leaves the counters alone
    reprogram(MODE_UNDEF, 1'b0, '0);
    send_byte(8'hFF);
    send_byte(8'h00);
    reprogram(MODE3, 1'b0, '0);
    send_byte(8'h81);
    reprogram(MODE4, 1'b1, 24'o76543210);
    send_byte(8'h7E);
    reprogram(MODE6, 1'b0, '0);
    send_byte(8'hC0);
    reprogram(MODE0, 1'b1, 24'o01234567);
    send_byte(8'h55);

    // Land past the last column of the narrow gapped mode and wrap to the next row
    reprogram(MODE2, 1'($urandom_range(0, 1)), rand_palette());
    walk_to(0, 41);
    reprogram(MODE6, 1'($urandom_range(0, 1)), rand_palette());
    walk_to(1, 0);

    // Random settings in phases of random length
    taken = 0;
    while (taken < RANDOM_BYTES) begin
      mode = ($urandom_range(0, 9) == 0) ? MODE_UNDEF : 3'($urandom_range(MODE0, MODE6));
      reprogram(mode, 1'($urandom_range(0, 1)), rand_palette());
      no_gaps = ($urandom_range(0, 3) == 0);
      count   = $urandom_range(4, 40);
      repeat (count) send_byte(rand_byte());
      if (mode != MODE_UNDEF) taken += count;
    end

    drain();
    if (tracker.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/sbpd_pkg.sv
rtl/core/sbpd_if.sv
rtl/core/sbpd_cell.sv
rtl/core/sbpd_loader.sv
rtl/core/screen_byte_pixel_decoder.sv
bench/tb_top.sv
